// File: rtl/ofra_pkg.sv
package ofra_pkg;

	localparam int ID_W = 16;
	localparam int LEN_W = 12;
	localparam int SLOT_W = 5;
	localparam int QUEUE_SLOTS_DEF = 32;
	localparam int MOD_STEP = 4;
	localparam int ENTRY_W = ID_W + 2 + LEN_W;
	localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 12'd1024;

	typedef enum logic {
		OP_RECEIVE = 1'b0,
		OP_PROCESS = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		PK_FULL   = 2'd0,
		PK_FIRST  = 2'd1,
		PK_MIDDLE = 2'd2,
		PK_LAST   = 2'd3
	} packet_kind_t;

	typedef enum logic [2:0] {
		RK_STORED    = 3'd0,
		RK_STALE     = 3'd1,
		RK_BUSY      = 3'd2,
		RK_TOO_LONG  = 3'd3,
		RK_EMPTY     = 3'd4,
		RK_DELIVERED = 3'd5,
		RK_DONE      = 3'd6
	} result_kind_t;

	typedef struct packed {
		op_t                opcode;
		logic [ID_W-1:0]    packet_id;
		packet_kind_t       packet_kind;
		logic [LEN_W-1:0]   payload_len;
	} item_t;

	typedef struct packed {
		result_kind_t       result_kind;
		logic [SLOT_W-1:0]  slot_index;
		logic [ID_W-1:0]    out_id;
		logic [LEN_W-1:0]   out_len;
		logic               message_end;
		logic               last_result;
	} result_t;

	typedef struct packed {
		logic load;
		logic mod_go;
		logic recv_emit;
		logic walk_init;
		logic msg_start;
		logic scan_rd;
		logic scan_adv;
		logic scan_done;
		logic dlv_rd;
		logic dlv_emit;
		logic done_emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic         mod_done;
		logic         holds;
		packet_kind_t kind;
		logic         first;
		logic         off_last;
		logic         off_end;
		logic         dlv_end;
	} dp_status_t;

endpackage

// File: rtl/ofra_ram.sv
module ofra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/ofra_slot_mod.sv
module ofra_slot_mod
	import ofra_pkg::*;
#(
	parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           go,
	input  logic [ID_W-1:0]                id,
	output logic                           done,
	output logic [$clog2(QUEUE_SLOTS)-1:0] rem
);

	localparam int SW = $clog2(QUEUE_SLOTS);
	localparam int STEPS = ID_W / MOD_STEP;
	localparam int CW = $clog2(STEPS + 1);
	localparam logic [SW:0] QV = (SW + 1)'(QUEUE_SLOTS);

	logic [ID_W-1:0] div_q;
	logic [SW-1:0]   rem_q;
	logic [CW-1:0]   cnt_q;
	logic [SW-1:0]   rem_nx;

	// long division remainder, MOD_STEP dividend bits per cycle
	always_comb begin
		logic [SW:0] t;
		rem_nx = rem_q;
		for (int k = 0; k < MOD_STEP; k++) begin
			t = {rem_nx, div_q[ID_W-1-k]};
			if (t >= QV) begin
				t = t - QV;
			end
			rem_nx = t[SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (go) begin
			cnt_q <= CW'(STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			div_q <= id;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			div_q <= div_q << MOD_STEP;
			rem_q <= rem_nx;
		end
	end

	assign done = (cnt_q == '0);
	assign rem = rem_q;

endmodule

// File: rtl/ofra_datapath.sv
module ofra_datapath
	import ofra_pkg::*;
#(
	parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  item_t            item,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_data,
	input  ctrl_cmd_t        cmd,
	output dp_status_t       status,
	output logic             result_strobe,
	output result_t          result
);

	localparam int SW = $clog2(QUEUE_SLOTS);
	localparam int OW = $clog2(QUEUE_SLOTS + 1);
	localparam logic [SW-1:0] SLOT_LAST = SW'(QUEUE_SLOTS - 1);

	item_t              item_q;
	logic [LEN_W-1:0]   max_payload_q;
	logic [QUEUE_SLOTS-1:0] valid_q;
	logic [ID_W-1:0]    last_q;
	logic [SW-1:0]      head_q;
	logic [SW-1:0]      scan_slot_q;
	logic [ID_W-1:0]    scan_id_q;
	logic [ID_W-1:0]    end_id_q;
	logic [OW-1:0]      off_q;
	logic               first_q;
	logic               valid_s1;
	logic               strobe_q;
	result_t            result_q;

	logic               mod_done;
	logic [SW-1:0]      rx_slot;
	logic [ID_W-1:0]    diff;
	logic               stale;
	result_kind_t       rx_kind;
	logic               store;
	logic [SW-1:0]      head_inc;
	logic [SW-1:0]      scan_inc;
	logic [ID_W-1:0]    next_id;
	logic               rd_en;
	logic [SW-1:0]      rd_addr;
	logic [ENTRY_W-1:0] rd_data;
	logic [ID_W-1:0]    rd_seq;
	packet_kind_t       rd_kind;
	logic [LEN_W-1:0]   rd_len;

	ofra_slot_mod #(
		.QUEUE_SLOTS(QUEUE_SLOTS)
	) u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (cmd.mod_go),
		.id    (item.packet_id),
		.done  (mod_done),
		.rem   (rx_slot)
	);

	ofra_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_SLOTS)
	) u_ram (
		.clk    (clk),
		.wr_en  (store),
		.wr_addr(rx_slot),
		.wr_data({item_q.packet_id, item_q.packet_kind, item_q.payload_len}),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign rd_seq  = rd_data[ENTRY_W-1 -: ID_W];
	assign rd_kind = packet_kind_t'(rd_data[LEN_W +: 2]);
	assign rd_len  = rd_data[LEN_W-1:0];

	assign rd_en   = cmd.scan_rd | cmd.dlv_rd;
	assign rd_addr = cmd.dlv_rd ? head_q : scan_slot_q;

	// id wrap restarts at slot 0
	assign head_inc = (head_q == SLOT_LAST || next_id == '1) ? '0 : head_q + 1'b1;
	assign scan_inc = (scan_slot_q == SLOT_LAST || scan_id_q == '1) ? '0 :
		scan_slot_q + 1'b1;
	assign next_id  = last_q + 1'b1;

	// receive verdict
	assign diff  = item_q.packet_id - last_q;
	assign stale = (diff == '0) || diff[ID_W-1];

	always_comb begin
		if (item_q.payload_len > max_payload_q) begin
			rx_kind = RK_TOO_LONG;
		end else if (item_q.payload_len == '0) begin
			rx_kind = RK_EMPTY;
		end else if (stale) begin
			rx_kind = RK_STALE;
		end else if (valid_q[rx_slot]) begin
			rx_kind = RK_BUSY;
		end else begin
			rx_kind = RK_STORED;
		end
	end

	assign store = cmd.recv_emit && (rx_kind == RK_STORED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
			valid_q       <= '0;
			last_q        <= '1;
			head_q        <= '0;
			strobe_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_payload_q <= cfg_data;
			end
			if (store) begin
				valid_q[rx_slot] <= 1'b1;
			end
			if (cmd.dlv_emit) begin
				valid_q[head_q] <= 1'b0;
				last_q          <= next_id;
				head_q          <= head_inc;
			end
			strobe_q <= cmd.recv_emit | cmd.dlv_emit | cmd.done_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (rd_en) begin
			valid_s1 <= valid_q[rd_addr];
		end
		if (cmd.walk_init) begin
			off_q <= '0;
		end else if (cmd.scan_adv || cmd.scan_done) begin
			off_q <= off_q + 1'b1;
		end
		if (cmd.msg_start) begin
			scan_slot_q <= cmd.dlv_emit ? head_inc : head_q;
			scan_id_q   <= cmd.dlv_emit ? next_id + 1'b1 : next_id;
			first_q     <= 1'b1;
		end else if (cmd.scan_adv) begin
			scan_slot_q <= scan_inc;
			scan_id_q   <= scan_id_q + 1'b1;
			first_q     <= 1'b0;
		end
		if (cmd.scan_done) begin
			end_id_q <= scan_id_q;
		end
		if (cmd.recv_emit) begin
			result_q.result_kind <= rx_kind;
			result_q.slot_index  <= SLOT_W'(rx_slot);
			result_q.out_id      <= item_q.packet_id;
			result_q.out_len     <= item_q.payload_len;
			result_q.message_end <= 1'b0;
			result_q.last_result <= 1'b1;
		end else if (cmd.dlv_emit) begin
			result_q.result_kind <= RK_DELIVERED;
			result_q.slot_index  <= SLOT_W'(head_q);
			result_q.out_id      <= next_id;
			result_q.out_len     <= rd_len;
			result_q.message_end <= (next_id == end_id_q);
			result_q.last_result <= 1'b0;
		end else if (cmd.done_emit) begin
			result_q.result_kind <= RK_DONE;
			result_q.slot_index  <= '0;
			result_q.out_id      <= last_q;
			result_q.out_len     <= '0;
			result_q.message_end <= 1'b0;
			result_q.last_result <= 1'b1;
		end
	end

	assign status.mod_done = mod_done;
	assign status.holds    = valid_s1 && (rd_seq == scan_id_q);
	assign status.kind     = rd_kind;
	assign status.first    = first_q;
	assign status.off_last = ({1'b0, off_q} + 1'b1) >= (OW + 1)'(QUEUE_SLOTS);
	assign status.off_end  = off_q >= OW'(QUEUE_SLOTS);
	assign status.dlv_end  = (next_id == end_id_q);

	assign result_strobe = strobe_q;
	assign result        = result_q;

endmodule

// File: rtl/ofra_ctrl.sv
module ofra_ctrl
	import ofra_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  op_t        opcode,
	input  dp_status_t status,
	output logic       busy,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_MOD      = 8'b0000_0010,
		S_RECV     = 8'b0000_0100,
		S_SCAN_RD  = 8'b0000_1000,
		S_SCAN_CHK = 8'b0001_0000,
		S_DLV_RD   = 8'b0010_0000,
		S_DLV_EMIT = 8'b0100_0000,
		S_DONE     = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_nx;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (opcode == OP_RECEIVE) begin
						cmd.mod_go = 1'b1;
						state_nx   = S_MOD;
					end else begin
						cmd.walk_init = 1'b1;
						cmd.msg_start = 1'b1;
						state_nx      = S_SCAN_RD;
					end
				end
			end
			S_MOD: begin
				if (status.mod_done) begin
					state_nx = S_RECV;
				end
			end
			S_RECV: begin
				cmd.recv_emit = 1'b1;
				state_nx      = S_IDLE;
			end
			S_SCAN_RD: begin
				cmd.scan_rd = 1'b1;
				state_nx    = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				state_nx = S_DONE;
				if (status.holds) begin
					if ((status.first && status.kind == PK_FULL) ||
					    (!status.first && status.kind == PK_LAST)) begin
						cmd.scan_done = 1'b1;
						state_nx      = S_DLV_RD;
					end else if ((status.first && status.kind == PK_FIRST) ||
					             (!status.first && status.kind == PK_MIDDLE)) begin
						if (!status.off_last) begin
							cmd.scan_adv = 1'b1;
							state_nx     = S_SCAN_RD;
						end
					end
				end
			end
			S_DLV_RD: begin
				cmd.dlv_rd = 1'b1;
				state_nx   = S_DLV_EMIT;
			end
			S_DLV_EMIT: begin
				cmd.dlv_emit = 1'b1;
				if (!status.dlv_end) begin
					state_nx = S_DLV_RD;
				end else if (status.off_end) begin
					state_nx = S_DONE;
				end else begin
					cmd.msg_start = 1'b1;
					state_nx      = S_SCAN_RD;
				end
			end
			S_DONE: begin
				cmd.done_emit = 1'b1;
				state_nx      = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// File: rtl/ordered_fragment_reassembly_window.sv
// receive: the slot remainder unit runs, then the verdict goes out through the result
//   register on the strobe; next item accepted in the strobe cycle
// process: each slot checked passes a read and a check state, each delivered slot a
//   read and an emit state, and the done result comes from the done state
// results leave one at a time on a single-cycle strobe and cannot be stalled
// reset: window empty, id 0 expected next, max_payload 1024
module ordered_fragment_reassembly_window
	import ofra_pkg::*;
#(
	parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  item_t            item,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_data,
	output logic             result_strobe,
	output result_t          result
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	ofra_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.opcode(item.opcode),
		.status(status),
		.busy  (busy),
		.cmd   (cmd)
	);

	ofra_datapath #(
		.QUEUE_SLOTS(QUEUE_SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.status       (status),
		.result_strobe(result_strobe),
		.result       (result)
	);

endmodule

// File: rtl/ofra_checker.sv
module ofra_checker
	import ofra_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    result_strobe,
	input result_t result
);

	// an accepted transfer keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("not busy after accepted transfer");

	// nothing follows the final result of an item
	a_last_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.last_result |=> !result_strobe)
		else $error("result right after final result");

	// more results pending keeps new transfers out
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !result.last_result |-> busy)
		else $error("idle while results pending");

	a_deliver_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.result_kind == RK_DELIVERED |-> !result.last_result)
		else $error("delivered result marked last");

	a_done_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.result_kind == RK_DONE |->
			result.last_result && result.slot_index == '0 && result.out_len == '0 &&
			!result.message_end)
		else $error("malformed process done result");

endmodule

bind ordered_fragment_reassembly_window ofra_checker u_ofra_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_strobe(result_strobe),
	.result       (result)
);

// File: bench/testbench.sv
module testbench;
	import ofra_pkg::*;

	localparam int SLOTS = QUEUE_SLOTS_DEF;
	localparam int RANDOM_ITEMS = 260;
	localparam int STALL_LIMIT = 1000;

	typedef enum int {
		BLK_MIDDLE_HEAD,
		BLK_LAST_HEAD,
		BLK_FULL_INSIDE,
		BLK_FIRST_INSIDE,
		BLK_BEYOND
	} blocker_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	item_t item;
	logic cfg_we;
	logic [LEN_W-1:0] cfg_data;
	logic result_strobe;
	result_t result;

	// predicted window state
	logic win_valid [SLOTS];
	logic [ID_W-1:0] win_id [SLOTS];
	packet_kind_t win_kind [SLOTS];
	logic [LEN_W-1:0] win_len [SLOTS];
	logic [ID_W-1:0] delivered_id = 16'hFFFF;
	logic [LEN_W-1:0] payload_limit = MAX_PAYLOAD_RST;

	result_t due_results [$];
	result_t oldest_due;
	int failures = 0;
	int items_sent = 0;
	int stall_cycles = 0;
	bit gaps_on = 1'b1;

	ordered_fragment_reassembly_window DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.result_strobe(result_strobe),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [SLOT_W-1:0] slot_of(input logic [ID_W-1:0] id);
		return SLOT_W'(id % SLOTS);
	endfunction

	function automatic bit slot_holds(input logic [ID_W-1:0] id);
		return win_valid[slot_of(id)] && win_id[slot_of(id)] == id;
	endfunction

	task automatic predict_reassembly(input item_t it);
		result_t r;
		logic [SLOT_W-1:0] s;
		logic [ID_W-1:0] gap;
		logic [ID_W-1:0] base;
		logic [ID_W-1:0] cid;
		int i;
		int j;
		int last_j;
		bit whole;
		r = '0;
		if (it.opcode == OP_RECEIVE) begin
			s = slot_of(it.packet_id);
			gap = it.packet_id - delivered_id;
			r.slot_index = s;
			r.out_id = it.packet_id;
			r.out_len = it.payload_len;
			r.last_result = 1'b1;
			if (it.payload_len > payload_limit) begin
				r.result_kind = RK_TOO_LONG;
			end else if (it.payload_len == '0) begin
				r.result_kind = RK_EMPTY;
			end else if (gap == '0 || gap > 16'h7FFF) begin
				r.result_kind = RK_STALE;
			end else if (win_valid[s]) begin
				r.result_kind = RK_BUSY;
			end else begin
				win_valid[s] = 1'b1;
				win_id[s] = it.packet_id;
				win_kind[s] = it.packet_kind;
				win_len[s] = it.payload_len;
				r.result_kind = RK_STORED;
			end
			due_results = {due_results, r};
		end else begin
			base = delivered_id + 16'd1;
			i = 0;
			while (i < SLOTS) begin
				cid = ID_W'(base + ID_W'(i));
				if (!slot_holds(cid))
					break;
				whole = 1'b0;
				last_j = i;
				if (win_kind[slot_of(cid)] == PK_FULL) begin
					whole = 1'b1;
				end else if (win_kind[slot_of(cid)] == PK_FIRST) begin
					for (j = i + 1; j < SLOTS; j++) begin
						cid = ID_W'(base + ID_W'(j));
						if (!slot_holds(cid))
							break;
						if (win_kind[slot_of(cid)] == PK_LAST) begin
							last_j = j;
							whole = 1'b1;
							break;
						end
						if (win_kind[slot_of(cid)] != PK_MIDDLE)
							break;
					end
				end
				if (!whole)
					break;
				for (j = i; j <= last_j; j++) begin
					cid = ID_W'(base + ID_W'(j));
					r = '0;
					r.result_kind = RK_DELIVERED;
					r.slot_index = slot_of(cid);
					r.out_id = cid;
					r.out_len = win_len[slot_of(cid)];
					r.message_end = (j == last_j);
					due_results = {due_results, r};
					win_valid[slot_of(cid)] = 1'b0;
				end
				delivered_id = ID_W'(base + ID_W'(last_j));
				i = last_j + 1;
			end
			r = '0;
			r.result_kind = RK_DONE;
			r.out_id = delivered_id;
			r.last_result = 1'b1;
			due_results = {due_results, r};
		end
	endtask

	function automatic item_t rx_item(input logic [ID_W-1:0] id, input packet_kind_t kind,
			input logic [LEN_W-1:0] len);
		item_t it;
		it.opcode = OP_RECEIVE;
		it.packet_id = id;
		it.packet_kind = kind;
		it.payload_len = len;
		return it;
	endfunction

	// receive fields are don't-care on a process, so they carry random bits
	function automatic item_t process_item();
		item_t it;
		it.opcode = OP_PROCESS;
		it.packet_id = ID_W'($urandom);
		it.packet_kind = packet_kind_t'($urandom_range(0, 3));
		it.payload_len = LEN_W'($urandom);
		return it;
	endfunction

	// random descriptor that can never be stored
	function automatic item_t noise_item();
		item_t it;
		logic [ID_W-1:0] gap;
		it = rx_item(ID_W'($urandom), packet_kind_t'($urandom_range(0, 3)), LEN_W'($urandom));
		gap = it.packet_id - delivered_id;
		if (it.payload_len != '0 && it.payload_len <= payload_limit && gap != '0 &&
				gap < 16'h8000)
			it.packet_id[ID_W-1] = ~it.packet_id[ID_W-1];
		return it;
	endfunction

	function automatic logic [LEN_W-1:0] payload_draw();
		return LEN_W'($urandom_range(1, int'(payload_limit)));
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s expected %0d actual %0d", name, want, got);
			failures++;
		end
	endtask

	// called at a falling edge, returns at a falling edge
	task automatic transfer_item(input item_t it);
		if (gaps_on && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 7)) @(negedge clk);
		start = 1'b1;
		item = it;
		do @(posedge clk); while (busy);
		predict_reassembly(it);
		items_sent++;
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic set_payload_limit(input logic [LEN_W-1:0] value);
		while (due_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		payload_limit = value;
	endtask

	task automatic test_empty_window();
		transfer_item(process_item());
	endtask

	task automatic test_receive_verdicts();
		transfer_item(rx_item(16'd0, PK_FULL, 12'd1024));
		transfer_item(rx_item(16'd0, PK_FULL, 12'd5));
		transfer_item(rx_item(16'd1, PK_FULL, 12'd1025));
		transfer_item(rx_item(16'd1, PK_LAST, 12'd0));
		transfer_item(rx_item(16'hFFFF, PK_FULL, 12'd7));
		transfer_item(rx_item(16'h7FFF, PK_FIRST, 12'd3));
		transfer_item(process_item());
	endtask

	task automatic test_fragment_order();
		transfer_item(rx_item(16'd4, PK_LAST, 12'd40));
		transfer_item(rx_item(16'd2, PK_MIDDLE, 12'd20));
		transfer_item(process_item());
		transfer_item(rx_item(16'd1, PK_FIRST, 12'd10));
		transfer_item(rx_item(16'd3, PK_MIDDLE, 12'd30));
		transfer_item(rx_item(16'd5, PK_FULL, 12'd50));
		transfer_item(rx_item(16'd7, PK_LAST, 12'd70));
		transfer_item(rx_item(16'd6, PK_FIRST, 12'd60));
		transfer_item(process_item());
	endtask

	task automatic test_payload_limit();
		set_payload_limit(12'd1);
		transfer_item(rx_item(16'd8, PK_FULL, 12'd1));
		transfer_item(rx_item(16'd9, PK_FULL, 12'd2));
		set_payload_limit(12'hFFF);
		transfer_item(rx_item(16'd9, PK_FIRST, 12'hFFF));
		set_payload_limit(12'd0);
		transfer_item(rx_item(16'd10, PK_LAST, 12'd1));
		transfer_item(rx_item(16'd10, PK_LAST, 12'd0));
		transfer_item(process_item());
		set_payload_limit(MAX_PAYLOAD_RST);
		transfer_item(rx_item(16'd10, PK_LAST, 12'd1024));
		transfer_item(process_item());
	endtask

	// shuffled whole messages with processes, duplicates and noise mixed in
	task automatic send_batch();
		item_t pkts [$];
		item_t tmp;
		logic [ID_W-1:0] id;
		int target;
		int k;
		int n;
		id = delivered_id + 16'd1;
		target = $urandom_range(4, 24);
		while (pkts.size() < target) begin
			if ($urandom_range(0, 1) == 0) begin
				pkts = {pkts, rx_item(id, PK_FULL, payload_draw())};
				id++;
			end else begin
				k = $urandom_range(0, 4);
				pkts = {pkts, rx_item(id, PK_FIRST, payload_draw())};
				id++;
				repeat (k) begin
					pkts = {pkts, rx_item(id, PK_MIDDLE, payload_draw())};
					id++;
				end
				pkts = {pkts, rx_item(id, PK_LAST, payload_draw())};
				id++;
			end
		end
		for (n = pkts.size() - 1; n > 0; n--) begin
			k = $urandom_range(0, n);
			tmp = pkts[n];
			pkts[n] = pkts[k];
			pkts[k] = tmp;
		end
		for (n = 0; n < pkts.size(); n++) begin
			if ($urandom_range(0, 7) == 0)
				transfer_item(process_item());
			if ($urandom_range(0, 9) == 0)
				transfer_item(noise_item());
			if (n > 0 && $urandom_range(0, 11) == 0)
				transfer_item(pkts[$urandom_range(0, n - 1)]);
			transfer_item(pkts[n]);
		end
		transfer_item(process_item());
	endtask

	// longest message the window holds; the first walk runs out of slots
	task automatic send_long_message();
		logic [ID_W-1:0] id;
		id = delivered_id + 16'd1;
		transfer_item(rx_item(id, PK_FULL, payload_draw()));
		id++;
		transfer_item(rx_item(id, PK_FIRST, payload_draw()));
		id++;
		repeat (SLOTS - 2) begin
			transfer_item(rx_item(id, PK_MIDDLE, payload_draw()));
			id++;
		end
		transfer_item(process_item());
		transfer_item(rx_item(id, PK_LAST, payload_draw()));
		transfer_item(process_item());
	endtask

	task automatic test_random_traffic();
		int first_item;
		int batch;
		first_item = items_sent;
		batch = 0;
		while (items_sent - first_item < RANDOM_ITEMS) begin
			if (items_sent - first_item > RANDOM_ITEMS * 3 / 4)
				gaps_on = 1'b0;
			if ($urandom_range(0, 2) == 0)
				set_payload_limit($urandom_range(0, 1) ? 12'hFFF :
					LEN_W'($urandom_range(1, 4095)));
			if (batch % 4 == 1)
				send_long_message();
			else
				send_batch();
			batch++;
		end
	endtask

	// a malformed message at the head stalls the window for good, so this runs last
	task automatic test_blocked_window();
		logic [ID_W-1:0] b;
		blocker_t pick;
		b = delivered_id + 16'd1;
		pick = blocker_t'($urandom_range(0, 4));
		transfer_item(rx_item(b, PK_FULL, payload_draw()));
		case (pick)
			BLK_MIDDLE_HEAD: begin
				transfer_item(rx_item(b + 16'd1, PK_MIDDLE, payload_draw()));
				transfer_item(rx_item(b + 16'd2, PK_LAST, payload_draw()));
			end
			BLK_LAST_HEAD: begin
				transfer_item(rx_item(b + 16'd1, PK_LAST, payload_draw()));
			end
			BLK_FULL_INSIDE: begin
				transfer_item(rx_item(b + 16'd1, PK_FIRST, payload_draw()));
				transfer_item(rx_item(b + 16'd2, PK_FULL, payload_draw()));
				transfer_item(rx_item(b + 16'd3, PK_LAST, payload_draw()));
			end
			BLK_FIRST_INSIDE: begin
				transfer_item(rx_item(b + 16'd1, PK_FIRST, payload_draw()));
				transfer_item(rx_item(b + 16'd2, PK_FIRST, payload_draw()));
				transfer_item(rx_item(b + 16'd3, PK_LAST, payload_draw()));
			end
			default: begin
				transfer_item(rx_item(ID_W'(b + 16'd1 + ID_W'(SLOTS)), PK_FULL,
					payload_draw()));
				transfer_item(rx_item(b + 16'd2, PK_FULL, payload_draw()));
			end
		endcase
		transfer_item(process_item());
		transfer_item(rx_item(delivered_id + 16'h7FFF, PK_FULL, payload_draw()));
		transfer_item(rx_item(delivered_id + 16'h8000, PK_FULL, payload_draw()));
		transfer_item(rx_item(b + 16'd1, PK_FULL, payload_draw()));
		transfer_item(process_item());
	endtask

	always @(posedge clk) begin
		if (arst_n && result_strobe) begin
			if (due_results.size() == 0) begin
				$error("unexpected result transfer: result_kind %0d out_id %0d",
					result.result_kind, result.out_id);
				failures++;
			end else begin
				oldest_due = due_results.pop_front();
				check_field("result_kind", oldest_due.result_kind, result.result_kind);
				check_field("slot_index", oldest_due.slot_index, result.slot_index);
				check_field("out_id", oldest_due.out_id, result.out_id);
				check_field("out_len", oldest_due.out_len, result.out_len);
				check_field("message_end", oldest_due.message_end, result.message_end);
				check_field("last_result", oldest_due.last_result, result.last_result);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || result_strobe)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("testbench: FAIL");
		$finish;
	end

	initial begin
		for (int s = 0; s < SLOTS; s++)
			win_valid[s] = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_empty_window();
		test_receive_verdicts();
		test_fragment_order();
		test_payload_limit();
		test_random_traffic();
		test_blocked_window();
		while (due_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
